// ===== design/tsps_pkg.sv =====
// shared types and constants for the tcp single port server block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tsps_pkg;

    localparam logic [15:0] LISTEN_PORT_RST   = 16'd23;
    localparam logic [15:0] REPLY_BUF_RST     = 16'd576;
    localparam logic [15:0] HDR_LEN           = 16'd20;
    localparam logic [15:0] OPT_LEN           = 16'd8;
    localparam logic [15:0] WIN_OVERHEAD      = 16'd28;
    localparam logic [15:0] DATA_OVERHEAD     = 16'd48;

    // flag bit positions in flags_in
    localparam int unsigned F_SYN = 0;
    localparam int unsigned F_ACK = 1;
    localparam int unsigned F_FIN = 2;
    localparam int unsigned F_RST = 3;

    // register index, taken from paddr[2]
    localparam logic REG_LISTEN_PORT = 1'b0;
    localparam logic REG_REPLY_BUF   = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_RST    = 3'd1,
        KIND_SYNACK = 3'd2,
        KIND_FINACK = 3'd3,
        KIND_ACK    = 3'd4,
        KIND_DATA   = 3'd5
    } reply_kind_t;

    typedef enum logic [1:0] {
        ST_LISTEN    = 2'd0,
        ST_CONNECTED = 2'd1,
        ST_CLOSING   = 2'd2
    } conn_state_t;

    // front end classification, independent of connection state
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_RST   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SEG   = 2'd3
    } front_op_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_RST,
        ACT_CLEAR,
        ACT_RST_CLEAR,
        ACT_OPEN,
        ACT_SYN_AGAIN,
        ACT_FIN,
        ACT_DATA,
        ACT_APP_CLOSE,
        ACT_LAST_ACK
    } action_t;

    typedef struct packed {
        front_op_t   op;
        logic [3:0]  flags;
        logic [15:0] rport;
        logic [31:0] raddr;
        logic [31:0] ack_in;
        logic [31:0] seq_p1;
        logic [31:0] seq_plen;
        logic [31:0] seq_plen_p1;
        logic        plen_zero;
        logic        app_close;
        logic [15:0] data_n;
        logic [15:0] window;
    } item_t;

endpackage

// ===== design/tsps_front.sv =====
// front end: classifies one received segment header into a queue item
// depends on tsps_pkg; reads the configuration registers from the top level
`timescale 1ns / 1ps

module tsps_front (
    input  logic               checksum_ok,
    input  logic [15:0]        local_port,
    input  logic [15:0]        remote_port,
    input  logic [31:0]        remote_addr,
    input  logic [31:0]        seq_in,
    input  logic [31:0]        ack_in,
    input  logic [3:0]         flags_in,
    input  logic [15:0]        payload_length,
    input  logic signed [16:0] app_reply_length,
    input  logic [15:0]        listen_port,
    input  logic [15:0]        reply_buffer_size,
    output tsps_pkg::item_t    item
);
    import tsps_pkg::*;

    logic        port_ok;
    logic [15:0] space;
    logic [15:0] app_mag;
    logic [31:0] seq_plen;

    assign port_ok  = (listen_port != 16'd0) && (local_port == listen_port);
    assign space    = (reply_buffer_size >= DATA_OVERHEAD) ?
                      (reply_buffer_size - DATA_OVERHEAD) : 16'd0;
    assign app_mag  = app_reply_length[15:0];
    assign seq_plen = seq_in + {16'd0, payload_length};

    always_comb
    begin
        item.flags       = flags_in;
        item.rport       = remote_port;
        item.raddr       = remote_addr;
        item.ack_in      = ack_in;
        item.seq_p1      = seq_in + 32'd1;
        item.seq_plen    = seq_plen;
        item.seq_plen_p1 = seq_plen + 32'd1;
        item.plen_zero   = (payload_length == 16'd0);
        item.app_close   = app_reply_length[16];
        item.data_n      = (app_mag > space) ? space : app_mag;
        item.window      = (reply_buffer_size >= WIN_OVERHEAD) ?
                           (reply_buffer_size - WIN_OVERHEAD) : 16'd0;
        if (!checksum_ok)
        begin
            item.op = OP_NONE;
        end
        else if (!port_ok)
        begin
            // foreign port: reset unless the segment is itself a reset
            item.op = flags_in[F_RST] ? OP_NONE : OP_RST;
        end
        else if (flags_in[F_RST])
        begin
            item.op = OP_CLEAR;
        end
        else
        begin
            item.op = OP_SEG;
        end
    end

endmodule

// ===== design/tsps_queue.sv =====
// two-entry queue between the classifying front end and the back end
// depends on tsps_pkg for the item type
`timescale 1ns / 1ps

module tsps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsps_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tsps_pkg::item_t head_item
);
    import tsps_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/tsps_back.sv =====
// back end: connection state machine and registered reply output
// depends on tsps_pkg; takes items from tsps_queue
`timescale 1ns / 1ps

module tsps_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  tsps_pkg::item_t head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      reply_kind,
    output logic [31:0]     seq_out,
    output logic [31:0]     ack_out,
    output logic [15:0]     window_out,
    output logic [15:0]     reply_length,
    output logic            with_options,
    output logic [15:0]     data_length
);
    import tsps_pkg::*;

    conn_state_t state_reg, state_next;
    logic [15:0] peer_port_reg, peer_port_next;
    logic [31:0] peer_addr_reg, peer_addr_next;
    logic [31:0] local_seq_reg, local_seq_next;
    logic [31:0] remote_seq_reg, remote_seq_next;
    logic        out_valid_reg, out_valid_next;

    reply_kind_t kind_reg, kind_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] ack_reg, ack_next;
    logic [15:0] win_reg, win_next;
    logic [15:0] total_reg, total_next;
    logic        opts_reg, opts_next;
    logic [15:0] dlen_reg, dlen_next;

    action_t     act;
    logic        f_syn, f_ack, f_fin;
    logic        peer_ok;

    assign f_syn   = head_item.flags[F_SYN];
    assign f_ack   = head_item.flags[F_ACK];
    assign f_fin   = head_item.flags[F_FIN];
    assign peer_ok = (head_item.raddr == peer_addr_reg) &&
                     (head_item.rport == peer_port_reg);

    // output register frees up in the same cycle it is taken
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // decision from the queue head and the connection state
    always_comb
    begin
        act = ACT_NONE;
        case (head_item.op)
            OP_NONE:  act = ACT_NONE;
            OP_RST:   act = ACT_RST;
            OP_CLEAR: act = ACT_CLEAR;
            OP_SEG:
            begin
                case (state_reg)
                    ST_LISTEN:
                    begin
                        if (f_ack || f_fin)
                            act = ACT_RST_CLEAR;
                        else if (f_syn)
                            act = ACT_OPEN;
                        else
                            act = ACT_RST_CLEAR;
                    end
                    ST_CONNECTED:
                    begin
                        if (!peer_ok)
                            act = ACT_RST;
                        else if (f_syn)
                            act = f_ack ? ACT_RST_CLEAR : ACT_SYN_AGAIN;
                        else if (f_fin)
                            act = ACT_FIN;
                        else if (f_ack)
                        begin
                            if (head_item.plen_zero)
                                act = ACT_NONE;
                            else if (head_item.app_close)
                                act = ACT_APP_CLOSE;
                            else
                                act = ACT_DATA;
                        end
                        else
                            act = ACT_RST_CLEAR;
                    end
                    ST_CLOSING:
                    begin
                        if (f_ack && !f_fin)
                            act = ACT_NONE;
                        else if (f_fin)
                            act = ACT_LAST_ACK;
                        else
                            act = ACT_RST_CLEAR;
                    end
                    default:
                    begin
                        // unused code acts like closing without the last ack
                        if (f_ack && !f_fin)
                            act = ACT_NONE;
                        else
                            act = ACT_RST_CLEAR;
                    end
                endcase
            end
            default: act = ACT_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (pop)
        begin
            case (act)
                ACT_OPEN:                               state_next = ST_CONNECTED;
                ACT_FIN, ACT_APP_CLOSE:                 state_next = ST_CLOSING;
                ACT_CLEAR, ACT_RST_CLEAR, ACT_LAST_ACK: state_next = ST_LISTEN;
                default:                                state_next = state_reg;
            endcase
        end
    end

    // connection context and reply fields
    always_comb
    begin
        peer_port_next  = peer_port_reg;
        peer_addr_next  = peer_addr_reg;
        local_seq_next  = local_seq_reg;
        remote_seq_next = remote_seq_reg;
        kind_next       = KIND_NONE;
        seq_next        = 32'd0;
        ack_next        = 32'd0;
        win_next        = 16'd0;
        opts_next       = 1'b0;
        dlen_next       = 16'd0;
        case (act)
            ACT_RST:
            begin
                kind_next = KIND_RST;
                seq_next  = head_item.ack_in;
                ack_next  = head_item.seq_p1;
            end
            ACT_CLEAR:
            begin
                peer_port_next  = 16'd0;
                peer_addr_next  = 32'd0;
                local_seq_next  = 32'd0;
                remote_seq_next = 32'd0;
            end
            ACT_RST_CLEAR:
            begin
                peer_port_next  = 16'd0;
                peer_addr_next  = 32'd0;
                local_seq_next  = 32'd0;
                remote_seq_next = 32'd0;
                kind_next       = KIND_RST;
                seq_next        = head_item.ack_in;
                ack_next        = head_item.seq_p1;
            end
            ACT_OPEN:
            begin
                peer_port_next  = head_item.rport;
                peer_addr_next  = head_item.raddr;
                remote_seq_next = head_item.seq_p1;
                local_seq_next  = local_seq_reg + 32'd1;
                kind_next       = KIND_SYNACK;
                seq_next        = local_seq_reg;
                ack_next        = head_item.seq_p1;
                win_next        = head_item.window;
                opts_next       = 1'b1;
            end
            ACT_SYN_AGAIN:
            begin
                // resend with the initial sequence number
                remote_seq_next = head_item.seq_p1;
                kind_next       = KIND_SYNACK;
                seq_next        = local_seq_reg - 32'd1;
                ack_next        = head_item.seq_p1;
                win_next        = head_item.window;
                opts_next       = 1'b1;
            end
            ACT_FIN:
            begin
                remote_seq_next = head_item.seq_p1;
                kind_next       = KIND_FINACK;
                seq_next        = local_seq_reg;
                ack_next        = head_item.seq_p1;
                win_next        = head_item.window;
                opts_next       = 1'b1;
            end
            ACT_DATA:
            begin
                remote_seq_next = head_item.seq_plen;
                local_seq_next  = local_seq_reg + {16'd0, head_item.data_n};
                kind_next       = KIND_DATA;
                seq_next        = local_seq_reg;
                ack_next        = head_item.seq_plen;
                win_next        = head_item.window;
                dlen_next       = head_item.data_n;
            end
            ACT_APP_CLOSE:
            begin
                remote_seq_next = head_item.seq_plen_p1;
                local_seq_next  = local_seq_reg + 32'd1;
                kind_next       = KIND_FINACK;
                seq_next        = local_seq_reg;
                ack_next        = head_item.seq_plen;
                win_next        = head_item.window;
                opts_next       = 1'b1;
            end
            ACT_LAST_ACK:
            begin
                peer_port_next  = 16'd0;
                peer_addr_next  = 32'd0;
                local_seq_next  = 32'd0;
                remote_seq_next = 32'd0;
                kind_next       = KIND_ACK;
                seq_next        = local_seq_reg;
                ack_next        = remote_seq_reg;
                win_next        = head_item.window;
                opts_next       = 1'b1;
            end
            default:
            begin
                kind_next = KIND_NONE;
            end
        endcase
        // none replies carry all-zero fields, so zero length as well
        if (kind_next == KIND_NONE)
            total_next = 16'd0;
        else
            total_next = HDR_LEN + (opts_next ? OPT_LEN : 16'd0) + dlen_next;
        if (!pop)
        begin
            peer_port_next  = peer_port_reg;
            peer_addr_next  = peer_addr_reg;
            local_seq_next  = local_seq_reg;
            remote_seq_next = remote_seq_reg;
        end
    end

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LISTEN;
            peer_port_reg  <= 16'd0;
            peer_addr_reg  <= 32'd0;
            local_seq_reg  <= 32'd0;
            remote_seq_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            peer_port_reg  <= peer_port_next;
            peer_addr_reg  <= peer_addr_next;
            local_seq_reg  <= local_seq_next;
            remote_seq_reg <= remote_seq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            seq_reg   <= seq_next;
            ack_reg   <= ack_next;
            win_reg   <= win_next;
            total_reg <= total_next;
            opts_reg  <= opts_next;
            dlen_reg  <= dlen_next;
        end
    end

    assign reply_kind   = kind_reg;
    assign seq_out      = seq_reg;
    assign ack_out      = ack_reg;
    assign window_out   = win_reg;
    assign reply_length = total_reg;
    assign with_options = opts_reg;
    assign data_length  = dlen_reg;

endmodule

// ===== design/tcp_single_port_server_fsm.sv =====
// top level of the tcp single port server: configuration registers and wiring
// depends on tsps_pkg, tsps_front, tsps_queue and tsps_back
//
// Usage
//   Input channel (in_valid/in_ready) carries one received segment header
//   summary per transfer; output channel (out_valid/out_ready) returns exactly
//   one reply decision per input transfer, in order. reply_kind none means
//   no segment is to be sent; all other fields are then zero.
//   An APB-style port sets listen_port (address 0) and reply_buffer_size
//   (address 4); pready is always high, writes land on the access cycle.
//   A reply passes from the queue entry register to the output register, which
//   takes it and raises out_valid once the output is free.
//   Throughput: one segment per cycle while the receiver keeps taking replies;
//   the back end updates the connection state and sequence numbers per item.
//   A two-entry queue sits between the classifying front end and the back
//   end; when the receiver stalls the output register holds, the queue fills
//   and in_ready drops once two items are waiting.
//   Reset puts the connection in listen with cleared peer and sequence
//   numbers, listen_port to 23 and reply_buffer_size to 576.
`timescale 1ns / 1ps

module tcp_single_port_server_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               checksum_ok,
    input  logic [15:0]        local_port,
    input  logic [15:0]        remote_port,
    input  logic [31:0]        remote_addr,
    input  logic [31:0]        seq_in,
    input  logic [31:0]        ack_in,
    input  logic [3:0]         flags_in,
    input  logic [15:0]        payload_length,
    input  logic signed [16:0] app_reply_length,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         reply_kind,
    output logic [31:0]        seq_out,
    output logic [31:0]        ack_out,
    output logic [15:0]        window_out,
    output logic [15:0]        reply_length,
    output logic               with_options,
    output logic [15:0]        data_length
);
    import tsps_pkg::*;

    logic [15:0] listen_port_reg, listen_port_next;
    logic [15:0] reply_buf_reg, reply_buf_next;
    logic        cfg_wr;

    item_t       front_item;
    item_t       head_item;
    logic        q_full;
    logic        head_valid;
    logic        pop;
    logic        push;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        listen_port_next = listen_port_reg;
        reply_buf_next   = reply_buf_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_LISTEN_PORT: listen_port_next = pwdata[15:0];
                REG_REPLY_BUF:   reply_buf_next   = pwdata[15:0];
                default:         listen_port_next = listen_port_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LISTEN_PORT: prdata = {16'd0, listen_port_reg};
            REG_REPLY_BUF:   prdata = {16'd0, reply_buf_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_port_reg <= LISTEN_PORT_RST;
            reply_buf_reg   <= REPLY_BUF_RST;
        end
        else
        begin
            listen_port_reg <= listen_port_next;
            reply_buf_reg   <= reply_buf_next;
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    tsps_front u_front (
        .checksum_ok       (checksum_ok),
        .local_port        (local_port),
        .remote_port       (remote_port),
        .remote_addr       (remote_addr),
        .seq_in            (seq_in),
        .ack_in            (ack_in),
        .flags_in          (flags_in),
        .payload_length    (payload_length),
        .app_reply_length  (app_reply_length),
        .listen_port       (listen_port_reg),
        .reply_buffer_size (reply_buf_reg),
        .item              (front_item)
    );

    tsps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tsps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .reply_kind   (reply_kind),
        .seq_out      (seq_out),
        .ack_out      (ack_out),
        .window_out   (window_out),
        .reply_length (reply_length),
        .with_options (with_options),
        .data_length  (data_length)
    );

endmodule

// ===== design/tsps_checker.sv =====
// port-level checks on the reply channel of the tcp single port server
// depends on tsps_pkg; attached to tcp_single_port_server_fsm by bind
`timescale 1ns / 1ps

module tsps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  reply_kind,
    input logic [31:0] seq_out,
    input logic [31:0] ack_out,
    input logic [15:0] window_out,
    input logic [15:0] reply_length,
    input logic        with_options,
    input logic [15:0] data_length
);
    import tsps_pkg::*;

    // a stalled reply stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("reply dropped while stalled");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == KIND_NONE |->
        seq_out == 32'd0 && ack_out == 32'd0 && window_out == 16'd0 &&
        reply_length == 16'd0 && !with_options && data_length == 16'd0)
        else $error("no-reply transfer carries nonzero fields");

    a_rst_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == KIND_RST |->
        window_out == 16'd0 && reply_length == HDR_LEN && !with_options &&
        data_length == 16'd0)
        else $error("reset reply has wrong shape");

    a_ctl_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reply_kind == KIND_SYNACK || reply_kind == KIND_FINACK ||
        reply_kind == KIND_ACK) |->
        with_options && reply_length == HDR_LEN + OPT_LEN && data_length == 16'd0)
        else $error("control reply has wrong length or options");

    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == KIND_DATA |->
        !with_options && reply_length == HDR_LEN + data_length)
        else $error("data reply length mismatch");

endmodule

bind tcp_single_port_server_fsm tsps_checker u_tsps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_kind   (reply_kind),
    .seq_out      (seq_out),
    .ack_out      (ack_out),
    .window_out   (window_out),
    .reply_length (reply_length),
    .with_options (with_options),
    .data_length  (data_length)
);

// ===== tb/tb_tcp_single_port_server_fsm.sv =====
// self-checking testbench for the tcp single port server decision block
// depends on tsps_pkg and tcp_single_port_server_fsm; drives segment headers and checks
// every reply decision against a directed table or a predictor of the connection state machine
`timescale 1ns / 1ps

module tb_tcp_single_port_server_fsm;

    import tsps_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int DIR_N       = 24;

    localparam logic [3:0] FL_SYN = 4'b0001 << F_SYN;
    localparam logic [3:0] FL_ACK = 4'b0001 << F_ACK;
    localparam logic [3:0] FL_FIN = 4'b0001 << F_FIN;
    localparam logic [3:0] FL_RST = 4'b0001 << F_RST;

    localparam logic [15:0] LP0    = LISTEN_PORT_RST;
    localparam logic [15:0] PEER_P = 16'd49152;
    localparam logic [31:0] PEER_A = 32'hC0A8_0A05;

    typedef struct packed {
        logic        ck;
        logic [15:0] lport;
        logic [15:0] rport;
        logic [31:0] raddr;
        logic [31:0] sq;
        logic [31:0] ak;
        logic [3:0]  flags;
        logic [15:0] plen;
        logic [16:0] app;
    } seg_t;

    typedef struct packed {
        reply_kind_t kind;
        logic [31:0] sq;
        logic [31:0] ak;
        logic [15:0] win;
        logic [15:0] tlen;
        logic        opts;
        logic [15:0] dlen;
    } reply_t;

    typedef struct packed {
        seg_t   s;
        logic   typed;
        reply_t r;
    } dir_row_t;

    localparam reply_t NO_REPLY = '0;

    // typed rows hold the reply decision; the others are left to the predictor
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{'{1'b0, LP0, PEER_P, PEER_A, 32'h1, 32'h2, FL_SYN, 16'd0, 17'd0},
            1'b1, NO_REPLY},
        '{'{1'b1, 16'd80, PEER_P, PEER_A, 32'hFFFF_FFFF, 32'h1234_5678, 4'h0, 16'd0, 17'd0},
            1'b1, '{KIND_RST, 32'h1234_5678, 32'h0, 16'd0, 16'd20, 1'b0, 16'd0}},
        '{'{1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h5, 32'h6, FL_RST | FL_SYN,
            16'hFFFF, 17'h1FFFF}, 1'b1, NO_REPLY},
        '{'{1'b1, LP0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, FL_ACK, 16'd0, 17'd0},
            1'b1, '{KIND_RST, 32'hFFFF_FFFF, 32'h1, 16'd0, 16'd20, 1'b0, 16'd0}},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'h10, 32'h20, FL_FIN, 16'd0, 17'd0},
            1'b1, '{KIND_RST, 32'h20, 32'h11, 16'd0, 16'd20, 1'b0, 16'd0}},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'h7, 32'h8, 4'h0, 16'd0, 17'd0},
            1'b1, '{KIND_RST, 32'h8, 32'h8, 16'd0, 16'd20, 1'b0, 16'd0}},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'h1, 32'h1, 4'hF, 16'd0, 17'd0},
            1'b1, NO_REPLY},
        // open, then foreign peers, retransmitted syn and data
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'hFFFF_FFFF, 32'h0, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A ^ 32'h1, 32'h50, 32'h1, FL_ACK, 16'd100, 17'd10},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P + 16'd1, PEER_A, 32'h50, 32'h1, FL_ACK, 16'd100, 17'd10},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'd100, 32'h0, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'd101, 32'h1, FL_ACK, 16'hFFFF, 17'h0FFFF},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'd200, 32'h1, FL_ACK, 16'd0, 17'd40},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'd200, 32'h1, FL_ACK, 16'd10, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'd210, 32'h1, 4'h0, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        // syn with ack while connected aborts
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'h0, 32'h0, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, PEER_P, PEER_A, 32'h1, 32'h1, FL_SYN | FL_ACK, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        // peer close: fin, ack ignored, last fin
        '{'{1'b1, LP0, 16'h0, 32'h0, 32'hFFFF_FFF0, 32'h0, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, FL_FIN | FL_ACK, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, 16'h0, 32'h0, 32'h0, 32'h1, FL_ACK, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, 16'h0, 32'h0, 32'h0, 32'h2, FL_FIN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        // application close, then an unexpected syn while closing
        '{'{1'b1, LP0, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY},
        '{'{1'b1, LP0, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1, FL_ACK, 16'd1,
            17'h1FFFF}, 1'b0, NO_REPLY},
        '{'{1'b1, LP0, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0002, 32'h2, FL_SYN, 16'd0, 17'd0},
            1'b0, NO_REPLY}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               checksum_ok;
    logic [15:0]        local_port;
    logic [15:0]        remote_port;
    logic [31:0]        remote_addr;
    logic [31:0]        seq_in;
    logic [31:0]        ack_in;
    logic [3:0]         flags_in;
    logic [15:0]        payload_length;
    logic signed [16:0] app_reply_length;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         reply_kind;
    logic [31:0]        seq_out;
    logic [31:0]        ack_out;
    logic [15:0]        window_out;
    logic [15:0]        reply_length;
    logic               with_options;
    logic [15:0]        data_length;

    // predictor copy of the registers and the connection
    logic [15:0]  cfg_port;
    logic [15:0]  cfg_buf;
    conn_state_t  conn;
    logic [15:0]  peer_port_q;
    logic [31:0]  peer_addr_q;
    logic [31:0]  tx_seq;
    logic [31:0]  rx_seq;

    reply_t       pending_replies [$];
    int           mismatch_count = 0;
    int           segs_sent = 0;
    int           snd_idle_pct = 0;
    int           rcv_idle_pct = 0;
    logic         hold_req = 1'b0;
    int           stall_cycles;
    logic [15:0]  sess_port;
    logic [31:0]  sess_addr;

    tcp_single_port_server_fsm uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .checksum_ok      (checksum_ok),
        .local_port       (local_port),
        .remote_port      (remote_port),
        .remote_addr      (remote_addr),
        .seq_in           (seq_in),
        .ack_in           (ack_in),
        .flags_in         (flags_in),
        .payload_length   (payload_length),
        .app_reply_length (app_reply_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reply_kind       (reply_kind),
        .seq_out          (seq_out),
        .ack_out          (ack_out),
        .window_out       (window_out),
        .reply_length     (reply_length),
        .with_options     (with_options),
        .data_length      (data_length)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void drop_connection();
        conn        = ST_LISTEN;
        peer_port_q = 16'd0;
        peer_addr_q = 32'd0;
        tx_seq      = 32'd0;
        rx_seq      = 32'd0;
    endfunction

    function automatic logic [15:0] cur_window();
        return (cfg_buf >= WIN_OVERHEAD) ? cfg_buf - WIN_OVERHEAD : 16'd0;
    endfunction

    function automatic reply_t make_reply(input reply_kind_t k, input logic [31:0] sq,
                                          input logic [31:0] ak, input logic [15:0] win,
                                          input logic opts, input logic [15:0] dlen);
        reply_t r;
        r.kind = k;
        r.sq   = sq;
        r.ak   = ak;
        r.win  = win;
        r.opts = opts;
        r.dlen = dlen;
        r.tlen = HDR_LEN + (opts ? OPT_LEN : 16'd0) + dlen;
        return r;
    endfunction

    // stateless reset answers with the peer's ack and its seq plus one
    function automatic reply_t reset_reply(input seg_t s);
        return make_reply(KIND_RST, s.ak, s.sq + 32'd1, 16'd0, 1'b0, 16'd0);
    endfunction

    function automatic reply_t predict_reply(input seg_t s);
        logic [31:0] seq0;
        logic [31:0] ack0;
        logic [15:0] room;
        logic [15:0] n;
        if (!s.ck)
            return NO_REPLY;
        if (cfg_port == 16'd0 || s.lport != cfg_port)
            return s.flags[F_RST] ? NO_REPLY : reset_reply(s);
        if (s.flags[F_RST])
        begin
            drop_connection();
            return NO_REPLY;
        end
        case (conn)
            ST_LISTEN:
            begin
                if (s.flags[F_SYN] && !s.flags[F_ACK] && !s.flags[F_FIN])
                begin
                    conn        = ST_CONNECTED;
                    peer_port_q = s.rport;
                    peer_addr_q = s.raddr;
                    rx_seq      = s.sq + 32'd1;
                    seq0        = tx_seq;
                    tx_seq      = tx_seq + 32'd1;
                    return make_reply(KIND_SYNACK, seq0, rx_seq, cur_window(), 1'b1, 16'd0);
                end
            end
            ST_CONNECTED:
            begin
                if (s.raddr != peer_addr_q || s.rport != peer_port_q)
                    return reset_reply(s);
                if (s.flags[F_SYN])
                begin
                    // retransmitted syn gets the initial sequence number again
                    if (!s.flags[F_ACK])
                    begin
                        rx_seq = s.sq + 32'd1;
                        return make_reply(KIND_SYNACK, tx_seq - 32'd1, rx_seq, cur_window(),
                                          1'b1, 16'd0);
                    end
                end
                else if (s.flags[F_FIN])
                begin
                    rx_seq = s.sq + 32'd1;
                    conn   = ST_CLOSING;
                    return make_reply(KIND_FINACK, tx_seq, rx_seq, cur_window(), 1'b1, 16'd0);
                end
                else if (s.flags[F_ACK])
                begin
                    if (s.plen == 16'd0)
                        return NO_REPLY;
                    rx_seq = s.sq + 32'(s.plen);
                    seq0   = tx_seq;
                    if (!s.app[16])
                    begin
                        room   = (cfg_buf >= DATA_OVERHEAD) ? cfg_buf - DATA_OVERHEAD : 16'd0;
                        n      = (s.app[15:0] > room) ? room : s.app[15:0];
                        tx_seq = tx_seq + 32'(n);
                        return make_reply(KIND_DATA, seq0, rx_seq, cur_window(), 1'b0, n);
                    end
                    ack0   = rx_seq;
                    conn   = ST_CLOSING;
                    tx_seq = tx_seq + 32'd1;
                    rx_seq = rx_seq + 32'd1;
                    return make_reply(KIND_FINACK, seq0, ack0, cur_window(), 1'b1, 16'd0);
                end
            end
            default:
            begin
                if (s.flags[F_ACK] && !s.flags[F_FIN])
                    return NO_REPLY;
                if (s.flags[F_FIN] && conn == ST_CLOSING)
                begin
                    seq0 = tx_seq;
                    ack0 = rx_seq;
                    drop_connection();
                    return make_reply(KIND_ACK, seq0, ack0, cur_window(), 1'b1, 16'd0);
                end
            end
        endcase
        drop_connection();
        return reset_reply(s);
    endfunction

    function automatic logic [15:0] pick_plen();
        case ($urandom_range(9))
            0, 1:    return 16'd0;
            8:       return 16'hFFFF;
            9:       return 16'($urandom);
            default: return 16'($urandom_range(1, 1460));
        endcase
    endfunction

    function automatic logic [16:0] pick_app();
        case ($urandom_range(9))
            0:       return 17'h1FFFF;
            1:       return 17'h0FFFF;
            2:       return 17'd0;
            default: return 17'($urandom_range(1, 600));
        endcase
    endfunction

    function automatic seg_t noise_seg();
        seg_t s;
        s.ck    = ($urandom_range(9) != 0);
        s.lport = $urandom_range(1) ? cfg_port : 16'($urandom);
        s.rport = 16'($urandom);
        s.raddr = $urandom;
        s.sq    = $urandom;
        s.ak    = $urandom;
        s.flags = 4'($urandom);
        s.plen  = pick_plen();
        s.app   = ($urandom_range(9) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 65535));
        // some noise lands on the open connection
        if ($urandom_range(3) == 0)
        begin
            s.rport = sess_port;
            s.raddr = sess_addr;
        end
        return s;
    endfunction

    function automatic seg_t peer_seg(input logic [3:0] fl);
        seg_t s;
        s       = noise_seg();
        s.ck    = 1'b1;
        s.lport = cfg_port;
        s.rport = sess_port;
        s.raddr = sess_addr;
        s.flags = fl;
        s.plen  = 16'd0;
        s.app   = pick_app();
        return s;
    endfunction

    task automatic send_seg(input seg_t s, input logic typed = 1'b0,
                            input reply_t typed_r = NO_REPLY);
        reply_t p;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        checksum_ok      <= s.ck;
        local_port       <= s.lport;
        remote_port      <= s.rport;
        remote_addr      <= s.raddr;
        seq_in           <= s.sq;
        ack_in           <= s.ak;
        flags_in         <= s.flags;
        payload_length   <= s.plen;
        app_reply_length <= s.app;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_reply(s);
        pending_replies.push_back(typed ? typed_r : p);
        segs_sent++;
    endtask

    // one connection from a fresh peer: open, some traffic, then a close variant or none
    task automatic run_session();
        seg_t s;
        int   n;
        sess_port = 16'($urandom);
        sess_addr = $urandom;
        send_seg(peer_seg(FL_SYN));
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            s      = peer_seg(FL_ACK);
            s.plen = pick_plen();
            case ($urandom_range(15))
                0:       s.flags = FL_SYN;
                1:       s.raddr = s.raddr ^ (32'h1 << $urandom_range(31));
                2:       s.rport = s.rport ^ 16'(1 << $urandom_range(15));
                3:       s.ck = 1'b0;
                4:       s.lport = ~cfg_port;
                default: ;
            endcase
            send_seg(s);
        end
        case ($urandom_range(5))
            0:
            begin
                send_seg(peer_seg(FL_FIN | FL_ACK));
                send_seg(peer_seg(FL_ACK));
                send_seg(peer_seg(FL_FIN | FL_ACK));
            end
            1:
            begin
                s      = peer_seg(FL_ACK);
                s.plen = 16'($urandom_range(1, 1460));
                s.app  = 17'h1FFFF;
                send_seg(s);
                send_seg(peer_seg(FL_ACK));
                send_seg(peer_seg(FL_FIN | FL_ACK));
            end
            2:       send_seg(peer_seg(FL_RST));
            3:       send_seg(peer_seg(FL_SYN | FL_ACK));
            4:
            begin
                send_seg(peer_seg(FL_FIN));
                send_seg(peer_seg(FL_SYN));
            end
            default: ;
        endcase
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [2:0] addr, input logic [15:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== want)
            flag_mismatch("register readback", prdata, {16'd0, want});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers change only once every reply is out
    task automatic set_config(input logic [15:0] lp, input logic [15:0] bs);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        apb_write({REG_LISTEN_PORT, 2'b00}, {16'd0, lp});
        apb_write({REG_REPLY_BUF, 2'b00}, {16'd0, bs});
        apb_check({REG_LISTEN_PORT, 2'b00}, lp);
        apb_check({REG_REPLY_BUF, 2'b00}, bs);
        cfg_port = lp;
        cfg_buf  = bs;
    endtask

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                flag_mismatch("reply transfer with none pending", {29'd0, reply_kind}, 32'd0);
            else
            begin
                w = pending_replies.pop_front();
                if (reply_kind !== w.kind)
                    flag_mismatch("reply_kind", {29'd0, reply_kind}, {29'd0, w.kind});
                if (seq_out !== w.sq)
                    flag_mismatch("seq_out", seq_out, w.sq);
                if (ack_out !== w.ak)
                    flag_mismatch("ack_out", ack_out, w.ak);
                if (window_out !== w.win)
                    flag_mismatch("window_out", {16'd0, window_out}, {16'd0, w.win});
                if (reply_length !== w.tlen)
                    flag_mismatch("reply_length", {16'd0, reply_length}, {16'd0, w.tlen});
                if (with_options !== w.opts)
                    flag_mismatch("with_options", {31'd0, with_options}, {31'd0, w.opts});
                if (data_length !== w.dlen)
                    flag_mismatch("data_length", {16'd0, data_length}, {16'd0, w.dlen});
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int i;
        int k;
        int goal;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        checksum_ok      = 1'b0;
        local_port       = '0;
        remote_port      = '0;
        remote_addr      = '0;
        seq_in           = '0;
        ack_in           = '0;
        flags_in         = '0;
        payload_length   = '0;
        app_reply_length = '0;
        cfg_port         = LISTEN_PORT_RST;
        cfg_buf          = REPLY_BUF_RST;
        sess_port        = PEER_P;
        sess_addr        = PEER_A;
        drop_connection();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_check({REG_LISTEN_PORT, 2'b00}, LISTEN_PORT_RST);
        apb_check({REG_REPLY_BUF, 2'b00}, REPLY_BUF_RST);

        snd_idle_pct = 29;
        rcv_idle_pct = 76;
        for (i = 0; i < DIR_N; i++)
            send_seg(DIR_TAB[i].s, DIR_TAB[i].typed, DIR_TAB[i].r);

        for (k = 0; k < 6; k++)
        begin
            case (k)
                0:       set_config(16'd1, DATA_OVERHEAD);
                1:       set_config(16'hFFFF, 16'hFFFF);
                2:       set_config(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(48, 65535)));
                3:       set_config(LISTEN_PORT_RST, REPLY_BUF_RST);
                4:       set_config(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(48, 200)));
                default: set_config(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(48, 65535)));
            endcase
            snd_idle_pct = (k < 2) ? 29 : (k < 4) ? 76 : 0;
            rcv_idle_pct = (k < 2) ? 76 : (k < 4) ? 29 : 0;
            // receiver holds off while segments keep coming, filling the block
            if (k == 4)
                hold_req = 1'b1;
            goal = segs_sent + 64;
            while (segs_sent < goal)
            begin
                if ($urandom_range(3) == 0)
                    send_seg(noise_seg());
                else
                    run_session();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
